// ===== rtl/eab_pkg.sv =====
package eab_pkg;

  localparam int PPM_W   = 14;
  localparam int LEVEL_W = 3;
  localparam int STEP_W  = 7;
  localparam int OCT_W   = 4;
  localparam int COUNT_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Number of quotient bits the divider produces, one per cycle.
  localparam int DIV_STEPS = PPM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Status level that marks the ventilating phase.
  localparam logic [LEVEL_W-1:0] VENTILATING_LEVEL = 3'd4;
  // Lowest status level that counts as an alarm.
  localparam logic [LEVEL_W-1:0] ALARM_LEVEL = 3'd3;
  // Global permission for the piezo.
  localparam logic SOUND_ALLOWED = 1'b1;
  // Step value that means no step reached, and the step limit that means no limit.
  localparam logic signed [STEP_W-1:0] NO_STEP = -7'sd1;
  // Highest step the quotient can produce.
  localparam logic [5:0] STEP_SAT = 6'd63;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM_START   = 3'd0,
    REG_STEP_INTERVAL = 3'd1,
    REG_STEP_LIMIT    = 3'd2,
    REG_BASE_BEEPS    = 3'd3,
    REG_BEEPS_PER_STEP = 3'd4,
    REG_BEEP_CAP      = 3'd5,
    REG_BASE_OCTAVE   = 3'd6,
    REG_OCTAVE_CAP    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [PPM_W-1:0]         alarm_start_ppm;
    logic [PPM_W-1:0]         step_interval_ppm;
    logic signed [STEP_W-1:0] step_limit;
    logic [5:0]               base_beeps;
    logic [3:0]               beeps_per_step;
    logic [6:0]               beep_cap;
    logic [OCT_W-1:0]         base_octave;
    logic [OCT_W-1:0]         octave_cap;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [PPM_W-1:0] dividend;
    logic [PPM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PPM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/eab_if.sv =====
interface eab_tick_if;
  import eab_pkg::*;
  logic               valid;
  logic               ready;
  logic [PPM_W-1:0]   air_ppm;
  logic [LEVEL_W-1:0] status_level;
  logic               blink_enable;
  logic               sound_enable;

  modport source (output valid, output air_ppm, output status_level,
                  output blink_enable, output sound_enable, input ready);
  modport sink (input valid, input air_ppm, input status_level,
                input blink_enable, input sound_enable, output ready);
endinterface

interface eab_beep_if;
  import eab_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     blink_on;
  logic                     tone_start;
  logic                     tone_stop;
  logic                     note_is_g;
  logic [OCT_W-1:0]         beep_octave;
  logic signed [STEP_W-1:0] alarm_step;

  modport source (output valid, output blink_on, output tone_start, output tone_stop,
                  output note_is_g, output beep_octave, output alarm_step, input ready);
  modport sink (input valid, input blink_on, input tone_start, input tone_stop,
                input note_is_g, input beep_octave, input alarm_step, output ready);
endinterface

// ===== rtl/eab_cfg.sv =====
module eab_cfg
  import eab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_start_ppm   <= 14'd1000;
      cfg.step_interval_ppm <= 14'd200;
      cfg.step_limit        <= NO_STEP;
      cfg.base_beeps        <= 6'd1;
      cfg.beeps_per_step    <= 4'd1;
      cfg.beep_cap          <= 7'd8;
      cfg.base_octave       <= 4'd4;
      cfg.octave_cap        <= 4'd7;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ALARM_START:    cfg.alarm_start_ppm   <= cfg_data[PPM_W-1:0];
        REG_STEP_INTERVAL:  cfg.step_interval_ppm <= cfg_data[PPM_W-1:0];
        REG_STEP_LIMIT:     cfg.step_limit        <= $signed(cfg_data[STEP_W-1:0]);
        REG_BASE_BEEPS:     cfg.base_beeps        <= cfg_data[5:0];
        REG_BEEPS_PER_STEP: cfg.beeps_per_step    <= cfg_data[3:0];
        REG_BEEP_CAP:       cfg.beep_cap          <= cfg_data[6:0];
        REG_BASE_OCTAVE:    cfg.base_octave       <= cfg_data[OCT_W-1:0];
        REG_OCTAVE_CAP:     cfg.octave_cap        <= cfg_data[OCT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/eab_div.sv =====
module eab_div
  import eab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] count;
  logic [PPM_W-1:0]     rem;
  logic [PPM_W-1:0]     quo;
  logic [PPM_W-1:0]     dvs;
  logic [PPM_W:0]       shifted;
  logic [PPM_W:0]       diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign shifted = {rem, quo[PPM_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      count <= DIV_CNT_W'(DIV_STEPS - 1);
      rem   <= '0;
      quo   <= req.dividend;
      dvs   <= req.divisor;
    end else if (busy) begin
      count <= count - DIV_CNT_W'(1);
      rem   <= fits ? diff[PPM_W-1:0] : shifted[PPM_W-1:0];
      quo   <= {quo[PPM_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/escalating_alarm_beeper.sv =====
// Channel  Dir  Fields                                              Accepted when
// tick     in   air_ppm, status_level, blink_enable, sound_enable   valid && ready
// beep     out  blink_on, tone_start, tone_stop, note_is_g,         valid && ready
//               beep_octave, alarm_step
// cfg      in   cfg_wr_en, cfg_index, cfg_data                      cfg_wr_en
//
// An active tick at or above the start level runs through the restoring divider (one quotient
// bit per cycle), then the quotient is taken and the tick finishes. Other ticks skip the
// divider and go straight to the finish state. Reset (rst, synchronous, active high) restores
// the configuration defaults and the sequencer and alarm state, and clears the output valid.
// A new word is accepted while the result waits in the output register; a stalled beep channel
// holds the next result in the finish state until the register frees up.
module escalating_alarm_beeper
  import eab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  eab_tick_if.sink              tick,
  eab_beep_if.source            beep,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  eab_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  eab_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer state and the alarm state carried from tick to tick.
  state_t                   state, state_next;
  logic [LEVEL_W-1:0]       previous_level;
  logic                     blink_phase;
  logic signed [STEP_W-1:0] step_reached;
  logic [COUNT_W-1:0]       beep_count;

  // The captured word of the tick being worked on.
  logic                     cur_blink_en;
  logic                     cur_sound_en;
  logic                     cur_alarm;
  logic                     cur_above;
  logic [PPM_W-1:0]         quotient;

  // Output register.
  logic                     out_valid;
  logic                     out_blink_on;
  logic                     out_tone_start;
  logic                     out_tone_stop;
  logic                     out_note_is_g;
  logic [OCT_W-1:0]         out_beep_octave;
  logic signed [STEP_W-1:0] out_alarm_step;

  logic accept;
  logic above_now;
  logic finish;

  assign accept    = tick.valid && tick.ready;
  assign above_now = tick.air_ppm >= cfg.alarm_start_ppm;

  // Sequencer: idle until a word arrives, run the divider when a step must be derived,
  // then finish as soon as the output register can take the result.
  always_comb begin
    state_next      = state;
    tick.ready      = 1'b0;
    finish          = 1'b0;
    div_req.start   = 1'b0;
    // The divider sees the distance above the start level; a zero interval acts as one.
    div_req.dividend = tick.air_ppm - cfg.alarm_start_ppm;
    div_req.divisor  = (cfg.step_interval_ppm == '0) ? PPM_W'(1) : cfg.step_interval_ppm;
    unique case (state)
      ST_IDLE: begin
        tick.ready = 1'b1;
        if (tick.valid) begin
          if (!blink_phase && above_now) begin
            div_req.start = 1'b1;
            state_next    = ST_DIVIDE;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || beep.ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_blink_en <= tick.blink_enable;
      cur_sound_en <= tick.sound_enable;
      cur_alarm    <= tick.status_level >= ALARM_LEVEL;
      cur_above    <= above_now;
    end
    if (div_rsp.done) begin
      quotient <= div_rsp.quotient;
    end
  end

  // Finish logic: everything after the division is worked out here in combinational logic.
  logic signed [STEP_W-1:0] new_step;
  logic signed [STEP_W-1:0] step_next;
  logic [COUNT_W-1:0]       count_next;
  logic                     phase_next;
  logic                     start_tone;
  logic                     stop_tone;
  logic signed [11:0]       beep_limit_raw;
  logic signed [11:0]       beep_limit;
  logic signed [7:0]        half_step;
  logic signed [7:0]        octave_raw;
  logic signed [7:0]        octave_top;
  logic [OCT_W-1:0]         octave;

  always_comb begin
    // The step saturates at its 6-bit maximum before the limit applies; any limit other
    // than "no limit" clamps by signed minimum.
    new_step = (quotient[PPM_W-1:6] != '0) ? $signed({1'b0, STEP_SAT})
                                           : $signed({1'b0, quotient[5:0]});
    if (cfg.step_limit != NO_STEP && cfg.step_limit < new_step) begin
      new_step = cfg.step_limit;
    end

    step_next  = step_reached;
    count_next = beep_count;
    phase_next = blink_phase;
    start_tone = 1'b0;
    stop_tone  = 1'b0;

    if (blink_phase) begin
      // Quiet tick: the tone of the previous beep is detached.
      phase_next = 1'b0;
      stop_tone  = beep_count != '0;
    end else begin
      phase_next = cur_alarm && cur_blink_en;
      if (cur_above) begin
        // A rising step restarts the burst when sound is enabled.
        if (step_reached < new_step) begin
          step_next = new_step;
          if (cur_sound_en) begin
            count_next = COUNT_W'(1);
          end
        end
      end
    end

    beep_limit_raw = $signed({{5{step_next[STEP_W-1]}}, step_next})
                   * $signed({8'b0, cfg.beeps_per_step})
                   + $signed({6'b0, cfg.base_beeps});
    beep_limit = (beep_limit_raw > $signed({5'b0, cfg.beep_cap}))
               ? $signed({5'b0, cfg.beep_cap}) : beep_limit_raw;

    // Halving truncates toward zero, so the "no step" value gives zero.
    half_step  = step_next[STEP_W-1] ? ($signed({step_next[STEP_W-1], step_next}) + 8'sd1) >>> 1
                                     : $signed({step_next[STEP_W-1], step_next}) >>> 1;
    octave_raw = half_step + $signed({4'b0, cfg.base_octave});
    octave_top = (octave_raw > $signed({4'b0, cfg.octave_cap}))
               ? $signed({4'b0, cfg.octave_cap}) : octave_raw;
    octave     = octave_top[7] ? '0 : octave_top[OCT_W-1:0];

    if (!blink_phase && cur_above && count_next != '0) begin
      if ($signed({4'b0, count_next}) <= beep_limit) begin
        start_tone = cur_sound_en && SOUND_ALLOWED;
        count_next = count_next + COUNT_W'(1);
        phase_next = 1'b1;
      end else begin
        count_next = '0;
      end
    end
  end

  // Alarm state. The previous level and the leaving-ventilation reset are taken at
  // acceptance, because they depend only on the incoming word and the stored level.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= '0;
      blink_phase    <= 1'b0;
      step_reached   <= NO_STEP;
      beep_count     <= '0;
    end else if (accept) begin
      previous_level <= tick.status_level;
      if (previous_level == VENTILATING_LEVEL && tick.status_level != VENTILATING_LEVEL) begin
        step_reached <= NO_STEP;
      end
    end else if (finish) begin
      blink_phase  <= phase_next;
      step_reached <= step_next;
      beep_count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (beep.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Note and octave read as zero when no beep starts.
  always_ff @(posedge clk) begin
    if (finish) begin
      out_blink_on    <= phase_next;
      out_tone_start  <= start_tone;
      out_tone_stop   <= stop_tone;
      out_note_is_g   <= start_tone && step_next[0];
      out_beep_octave <= start_tone ? octave : '0;
      out_alarm_step  <= step_next;
    end
  end

  assign beep.valid       = out_valid;
  assign beep.blink_on    = out_blink_on;
  assign beep.tone_start  = out_tone_start;
  assign beep.tone_stop   = out_tone_stop;
  assign beep.note_is_g   = out_note_is_g;
  assign beep.beep_octave = out_beep_octave;
  assign beep.alarm_step  = out_alarm_step;

  // A new result only ever appears out of the finish state.
  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result appeared without a finish cycle");

  // The divider reports back only while the sequencer waits for it.
  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  // Starting and stopping the tone in the same tick cannot happen.
  a_start_stop_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_tone_start && out_tone_stop))
    else $error("tone started and stopped at once");

  // Without a beep, the note fields are clear.
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_tone_start) |-> (!out_note_is_g && out_beep_octave == '0))
    else $error("note fields set without a beep");

  // The step never falls below the "no step" value.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_reached >= NO_STEP)
    else $error("alarm step below the no-step value");

endmodule
